// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/dorl_pkg.sv =====
// package: widths, register indexes, reset values and shared types
`timescale 1ns / 1ps

package dorl_pkg;

    localparam int ADDR_W     = 32;
    localparam int BANK_W     = 2;
    localparam int ROW_W      = 18;
    localparam int COL_W      = 10;
    localparam int TIME10_W   = 10;
    localparam int LAT_W      = 12;
    localparam int TIME_W     = 32;
    localparam int NUM_BANKS  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAPPING_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TIME    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_CLOSE_TIME = 2'd3;

    // mapping codes
    localparam logic MAP_ROW_INTERLEAVE   = 1'b0;
    localparam logic MAP_BLOCK_INTERLEAVE = 1'b1;

    // reset values
    localparam logic [TIME10_W-1:0] RST_ACTIVATE_TIME  = 10'd100;
    localparam logic [TIME10_W-1:0] RST_COLUMN_TIME    = 10'd50;
    localparam logic [TIME10_W-1:0] RST_ROW_CLOSE_TIME = 10'd50;

    typedef struct packed {
        logic                mapping_mode;
        logic [TIME10_W-1:0] activate_time;
        logic [TIME10_W-1:0] column_time;
        logic [TIME10_W-1:0] row_close_time;
    } t_cfg;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_addr_fields;

    typedef struct packed {
        logic              row_hit;
        logic [LAT_W-1:0]  latency;
        logic [TIME_W-1:0] finish_time;
    } t_timing;

endpackage

// ===== src/dorl_cfg_regs.sv =====
// configuration registers with write port
`timescale 1ns / 1ps

module dorl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dorl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dorl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dorl_pkg::t_cfg                   o_cfg
);

    dorl_pkg::t_cfg r_cfg;
    dorl_pkg::t_cfg n_cfg;

    // decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                dorl_pkg::REG_MAPPING_MODE:   n_cfg.mapping_mode   = i_cfg_data[0];
                dorl_pkg::REG_ACTIVATE_TIME:  n_cfg.activate_time  = i_cfg_data;
                dorl_pkg::REG_COLUMN_TIME:    n_cfg.column_time    = i_cfg_data;
                dorl_pkg::REG_ROW_CLOSE_TIME: n_cfg.row_close_time = i_cfg_data;
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mapping_mode   <= dorl_pkg::MAP_ROW_INTERLEAVE;
            r_cfg.activate_time  <= dorl_pkg::RST_ACTIVATE_TIME;
            r_cfg.column_time    <= dorl_pkg::RST_COLUMN_TIME;
            r_cfg.row_close_time <= dorl_pkg::RST_ROW_CLOSE_TIME;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/dorl_addr_split.sv =====
// address split into bank, row and column
`timescale 1ns / 1ps

module dorl_addr_split (
    input  logic                          i_mapping_mode,
    input  logic [dorl_pkg::ADDR_W-1:0]   i_address,
    output dorl_pkg::t_addr_fields        o_fields
);

    always_comb begin
        if (i_mapping_mode == dorl_pkg::MAP_BLOCK_INTERLEAVE) begin
            // block interleave: column bits 6 and 7 stay zero
            o_fields.bank = i_address[7:6];
            o_fields.col  = {i_address[17:16], 2'b00, i_address[5:0]};
            o_fields.row  = i_address[27:10];
        end else begin
            // row interleave
            o_fields.bank = i_address[13:12];
            o_fields.col  = i_address[11:2];
            o_fields.row  = i_address[31:14];
        end
    end

endmodule

// ===== src/dorl_bank_state.sv =====
// per-bank open row tracking, latency and running time
`timescale 1ns / 1ps

module dorl_bank_state (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_update,
    input  dorl_pkg::t_cfg           i_cfg,
    input  dorl_pkg::t_addr_fields   i_fields,
    output dorl_pkg::t_timing        o_timing
);

    logic [dorl_pkg::NUM_BANKS-1:0] r_row_open;
    logic [dorl_pkg::ROW_W-1:0]     r_open_row [dorl_pkg::NUM_BANKS];
    logic [dorl_pkg::TIME_W-1:0]    r_global_time;
    logic [dorl_pkg::TIME_W-1:0]    n_global_time;

    logic                        w_open;
    logic                        w_hit;
    logic [dorl_pkg::LAT_W-1:0]  w_latency;

    // hit check against the selected bank
    assign w_open = r_row_open[i_fields.bank];
    assign w_hit  = w_open && (r_open_row[i_fields.bank] == i_fields.row);

    // latency: column always, activate on miss, precharge when another row was open
    always_comb begin
        w_latency = {2'b00, i_cfg.column_time};
        if (!w_hit) begin
            w_latency = w_latency + {2'b00, i_cfg.activate_time};
            if (w_open) begin
                w_latency = w_latency + {2'b00, i_cfg.row_close_time};
            end
        end
    end

    assign n_global_time = r_global_time
                         + {{(dorl_pkg::TIME_W-dorl_pkg::LAT_W){1'b0}}, w_latency};

    // open flags and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_open    <= '0;
            r_global_time <= '0;
        end else if (i_update) begin
            r_row_open[i_fields.bank] <= 1'b1;
            r_global_time             <= n_global_time;
        end
    end

    // open row per bank, only meaningful once the bank is open
    always_ff @(posedge i_clk) begin
        if (i_update && !w_hit) begin
            r_open_row[i_fields.bank] <= i_fields.row;
        end
    end

    assign o_timing.row_hit     = w_hit;
    assign o_timing.latency     = w_latency;
    assign o_timing.finish_time = n_global_time;

endmodule

// ===== src/dram_open_row_latency_model_top.sv =====
// top level: input register, address split, bank timing, result register
// Open-row DRAM bank timing model.
// Input channel: i_valid / o_stall carry one item, a 32-bit byte address.
// Output channel: o_valid / i_stall carry one result item: bank, row, col,
// row_hit, latency and the wrapping running time after the access.
// Configuration: the user drives i_cfg_we to write i_cfg_data into register
// i_cfg_index (0 mapping mode, 1 activate time, 2 column time, 3 precharge
// time) only while no item is in flight; the block does not enforce this.
// Path: input register, then result register. Throughput: one item per
// cycle while the receiver does not stall; the bank state is updated in
// the cycle the result register loads, so each item sees the previous one.
// Stall: the input register holds one item while a result waits; o_stall
// rises only when both registers are full and the receiver stalls.
// Reset: synchronous, active low; all banks closed, time zero, registers
// at their reset values, both registers empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dram_open_row_latency_model_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dorl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dorl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [dorl_pkg::ADDR_W-1:0]      i_address,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [dorl_pkg::BANK_W-1:0]      o_bank,
    output logic [dorl_pkg::ROW_W-1:0]       o_row,
    output logic [dorl_pkg::COL_W-1:0]       o_col,
    output logic                             o_row_hit,
    output logic [dorl_pkg::LAT_W-1:0]       o_latency,
    output logic [dorl_pkg::TIME_W-1:0]      o_finish_time
);

    dorl_pkg::t_cfg          w_cfg;
    dorl_pkg::t_addr_fields  w_fields;
    dorl_pkg::t_timing       w_timing;

    logic                        r_in_valid;
    logic [dorl_pkg::ADDR_W-1:0] r_in_address;
    logic                        r_out_valid;
    dorl_pkg::t_addr_fields      r_out_fields;
    dorl_pkg::t_timing           r_out_timing;

    logic w_out_blocked;
    logic w_advance;
    logic w_accept;

    // handshake control
    assign w_out_blocked = r_out_valid && i_stall;
    assign w_advance     = r_in_valid && !w_out_blocked;
    assign o_stall       = r_in_valid && w_out_blocked;
    assign w_accept      = i_valid && !o_stall;

    dorl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dorl_addr_split u_split (
        .i_mapping_mode (w_cfg.mapping_mode),
        .i_address      (r_in_address),
        .o_fields       (w_fields)
    );

    dorl_bank_state u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_advance),
        .i_cfg    (w_cfg),
        .i_fields (w_fields),
        .o_timing (w_timing)
    );

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_address <= i_address;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_fields <= w_fields;
            r_out_timing <= w_timing;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_bank        = r_out_fields.bank;
    assign o_row         = r_out_fields.row;
    assign o_col         = r_out_fields.col;
    assign o_row_hit     = r_out_timing.row_hit;
    assign o_latency     = r_out_timing.latency;
    assign o_finish_time = r_out_timing.finish_time;

    // a hit costs exactly the column time
    `ASSERT_IMPLY(a_hit_latency, i_clk, i_rst_n, w_advance && w_timing.row_hit,
        w_timing.latency == {2'b00, w_cfg.column_time})
    // input side stalls only behind a full, stalled result register
    `ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid && i_stall)
    // an item moved forward always shows up as a result next cycle
    `ASSERT_NEXT(a_advance_shows, i_clk, i_rst_n, w_advance, r_out_valid)
    // a held item keeps its address
    `ASSERT_NEXT(a_hold_address, i_clk, i_rst_n, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_address))

endmodule
